// ===== design/sme_pkg.sv =====
// shared types, constants and helpers for the stack machine executor
`default_nettype none
package sme_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int MEM_WORDS   = 256;
	localparam int STK_AW      = $clog2(STACK_DEPTH);
	localparam int MEM_AW      = $clog2(MEM_WORDS);
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int DIV_STEPS   = 32;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	localparam logic [3:0] OP_PUSHI   = 4'd0;
	localparam logic [3:0] OP_PUSHMEM = 4'd1;
	localparam logic [3:0] OP_POPMEM  = 4'd2;
	localparam logic [3:0] OP_ADD     = 4'd3;
	localparam logic [3:0] OP_SUB     = 4'd4;
	localparam logic [3:0] OP_MUL     = 4'd5;
	localparam logic [3:0] OP_DIV     = 4'd6;
	localparam logic [3:0] OP_SWAP    = 4'd7;
	localparam logic [3:0] OP_DROP    = 4'd8;
	localparam logic [3:0] OP_DUP     = 4'd9;
	localparam logic [3:0] OP_PRINT   = 4'd10;
	localparam logic [3:0] OP_HALT    = 4'd11;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_OVER  = 2'd1;
	localparam logic [1:0] ST_UNDER = 2'd2;
	localparam logic [1:0] ST_DIVZ  = 2'd3;

	typedef struct packed {
		logic [3:0]         mode;
		logic signed [31:0] imm_value;
		logic [7:0]         mem_address;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] printed_value;
		logic               print_valid;
		logic [4:0]         stack_depth;
		logic signed [31:0] top_value;
	} res_t;

	// signed result from a magnitude and a sign, clamped to the q16.16 range
	function automatic logic [31:0] sat_mag(input logic [47:0] m, input logic neg);
		logic [31:0] r;
		if (neg) begin
			if (m >= 48'h0000_8000_0000) r = 32'h8000_0000;
			else r = 32'd0 - m[31:0];
		end else begin
			if (m > 48'h0000_7FFF_FFFF) r = 32'h7FFF_FFFF;
			else r = m[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/sme_ram.sv =====
// generic single write port ram with one registered read port
`default_nettype none
module sme_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== design/stack_machine_executor_core.sv =====
// stack machine executor: sequencer, shared adder, multiplier and the two memories
// Executes one stack-machine instruction per cmd transfer and returns one result per
// instruction on res. Values are signed q16.16.
// cmd channel: cmd_valid/cmd_stall with payload cmd (mode, imm_value, mem_address).
// cmd_stall is low only while the sequencer is idle; one instruction is worked on at a time.
// res channel: res_valid/res_stall with payload res (status, printed_value, print_valid,
// stack_depth, top_value), held in an output register.
// Div runs a restoring divider one quotient bit per cycle through the shared 34 bit adder.
// cmd_stall drops in the same cycle that the result is registered, so transfers never
// overlap: the next instruction is taken only after the previous one is finished.
// A new instruction is taken while the previous result still waits in the output register;
// if the receiver stalls, a finished instruction waits until the register is free.
// Reset empties the stack and starts a clearing pass over the data memory, one word a cycle:
// cmd_stall stays high after reset until all MEM_WORDS (256) words are cleared.
// Halt empties the stack but keeps the memory contents.
`default_nettype none
module stack_machine_executor_core
	import sme_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_stall,
	input  wire cmd_t cmd,
	output logic      res_valid,
	input  wire logic res_stall,
	output res_t      res
);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_EXEC, S_PUSHMEM, S_SWAP, S_NEWTOP,
		S_OPERAND, S_MULSAT, S_DIV, S_DIVEND, S_DONE
	} state_t;

	state_t                 state_q;
	logic [MEM_AW-1:0]      clr_q;
	logic [DEPTH_W-1:0]     depth_q;
	logic [31:0]            top_q;
	logic [3:0]             op_q;
	logic [31:0]            imm_q;
	logic [MEM_AW-1:0]      addr_q;
	logic [1:0]             st_q;
	logic [31:0]            printed_q;
	logic                   pvalid_q;
	logic [63:0]            prod_q;
	logic [31:0]            rem_q;
	logic [31:0]            dq_q;
	logic [31:0]            dvs_q;
	logic                   neg_q;
	logic                   ovf_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic                   res_valid_q;
	res_t                   res_q;

	// memory ports
	logic                   stk_we;
	logic [STK_AW-1:0]      stk_waddr;
	logic [STK_AW-1:0]      stk_raddr;
	logic [31:0]            stk_rdata;
	logic                   mem_we;
	logic [MEM_AW-1:0]      mem_waddr;
	logic [31:0]            mem_wdata;
	logic [31:0]            mem_rdata;

	// decode
	logic                   empty;
	logic                   full;
	logic                   lt2;
	logic [1:0]             exec_st;
	logic                   exec_ok;
	logic                   res_load;

	// shared adder and operand magnitudes
	logic [33:0]            alu_a;
	logic [33:0]            alu_b;
	logic                   alu_sub;
	logic [33:0]            alu_sum;
	logic                   alu_neg;
	logic [31:0]            addsub_res;
	logic [32:0]            div_trial;
	logic [31:0]            mag_a;
	logic [31:0]            mag_b;
	logic [63:0]            prod_c;
	logic                   div_ovf;

	assign empty = (depth_q == '0);
	assign full  = (depth_q == DEPTH_W'(STACK_DEPTH));
	assign lt2   = (depth_q < DEPTH_W'(2));

	always_comb begin
		exec_st = ST_OK;
		unique case (op_q)
			OP_PUSHI, OP_PUSHMEM: begin
				if (full) exec_st = ST_OVER;
			end
			OP_POPMEM, OP_DROP, OP_PRINT: begin
				if (empty) exec_st = ST_UNDER;
			end
			OP_ADD, OP_SUB, OP_MUL, OP_SWAP: begin
				if (lt2) exec_st = ST_UNDER;
			end
			OP_DIV: begin
				// zero divisor is reported ahead of the missing second operand
				priority if (empty) exec_st = ST_UNDER;
				else if (top_q == '0) exec_st = ST_DIVZ;
				else if (lt2) exec_st = ST_UNDER;
				else exec_st = ST_OK;
			end
			OP_DUP: begin
				priority if (empty) exec_st = ST_UNDER;
				else if (full) exec_st = ST_OVER;
				else exec_st = ST_OK;
			end
			default: exec_st = ST_OK;
		endcase
	end

	assign exec_ok  = (exec_st == ST_OK);
	assign res_load = (state_q == S_DONE) && (!res_valid_q || !res_stall);

	// the top entry lives in top_q, the ram holds the entries below it
	assign stk_raddr = STK_AW'(depth_q - DEPTH_W'(2));
	assign stk_waddr = (state_q == S_SWAP) ? STK_AW'(depth_q - DEPTH_W'(2))
		: STK_AW'(depth_q - DEPTH_W'(1));
	assign stk_we = (state_q == S_SWAP)
		|| (state_q == S_PUSHMEM && !empty)
		|| (state_q == S_EXEC && exec_ok && !empty && (op_q == OP_PUSHI || op_q == OP_DUP));

	assign mem_we    = (state_q == S_CLEAR) || (state_q == S_EXEC && exec_ok && op_q == OP_POPMEM);
	assign mem_waddr = (state_q == S_CLEAR) ? clr_q : addr_q;
	assign mem_wdata = (state_q == S_CLEAR) ? '0 : top_q;

	sme_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (top_q),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	sme_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_data (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (addr_q),
		.rdata (mem_rdata)
	);

	assign div_trial = {rem_q, dq_q[31]};

	always_comb begin
		if (state_q == S_DIV) begin
			alu_a   = {1'b0, div_trial};
			alu_b   = {2'b00, dvs_q};
			alu_sub = 1'b1;
		end else begin
			alu_a   = {{2{stk_rdata[31]}}, stk_rdata};
			alu_b   = {{2{top_q[31]}}, top_q};
			alu_sub = (op_q == OP_SUB);
		end
	end

	assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + 34'(alu_sub);
	assign alu_neg = alu_sum[33];

	always_comb begin
		if (alu_sum[33:31] == 3'b000 || alu_sum[33:31] == 3'b111) addsub_res = alu_sum[31:0];
		else if (alu_sum[33]) addsub_res = 32'h8000_0000;
		else addsub_res = 32'h7FFF_FFFF;
	end

	assign mag_a   = stk_rdata[31] ? 32'd0 - stk_rdata : stk_rdata;
	assign mag_b   = top_q[31] ? 32'd0 - top_q : top_q;
	assign prod_c  = mag_a * mag_b;
	// quotient reaches 2^32 when the upper half of the dividend is not below the divisor
	assign div_ovf = ({16'd0, mag_a[31:16]} >= mag_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			depth_q     <= '0;
			top_q       <= '0;
			op_q        <= '0;
			imm_q       <= '0;
			addr_q      <= '0;
			st_q        <= ST_OK;
			printed_q   <= '0;
			pvalid_q    <= 1'b0;
			prod_q      <= '0;
			rem_q       <= '0;
			dq_q        <= '0;
			dvs_q       <= '0;
			neg_q       <= 1'b0;
			ovf_q       <= 1'b0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + MEM_AW'(1);
					if (clr_q == MEM_AW'(MEM_WORDS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (cmd_valid) begin
						op_q    <= cmd.mode;
						imm_q   <= cmd.imm_value;
						addr_q  <= MEM_AW'(cmd.mem_address);
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					st_q      <= exec_st;
					printed_q <= (exec_ok && op_q == OP_PRINT) ? top_q : '0;
					pvalid_q  <= exec_ok && (op_q == OP_PRINT);
					if (!exec_ok) begin
						state_q <= S_DONE;
					end else begin
						unique case (op_q)
							OP_PUSHI: begin
								top_q   <= imm_q;
								depth_q <= depth_q + DEPTH_W'(1);
								state_q <= S_DONE;
							end
							OP_PUSHMEM: state_q <= S_PUSHMEM;
							OP_POPMEM, OP_DROP, OP_PRINT: begin
								depth_q <= depth_q - DEPTH_W'(1);
								if (lt2) begin
									top_q   <= '0;
									state_q <= S_DONE;
								end else begin
									state_q <= S_NEWTOP;
								end
							end
							OP_ADD, OP_SUB, OP_MUL, OP_DIV: state_q <= S_OPERAND;
							OP_SWAP: state_q <= S_SWAP;
							OP_DUP: begin
								depth_q <= depth_q + DEPTH_W'(1);
								state_q <= S_DONE;
							end
							OP_HALT: begin
								depth_q <= '0;
								top_q   <= '0;
								state_q <= S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_PUSHMEM: begin
					top_q   <= mem_rdata;
					depth_q <= depth_q + DEPTH_W'(1);
					state_q <= S_DONE;
				end
				S_SWAP, S_NEWTOP: begin
					top_q   <= stk_rdata;
					state_q <= S_DONE;
				end
				S_OPERAND: begin
					neg_q <= stk_rdata[31] ^ top_q[31];
					unique case (op_q)
						OP_MUL: begin
							prod_q  <= prod_c;
							state_q <= S_MULSAT;
						end
						OP_DIV: begin
							rem_q   <= {16'd0, mag_a[31:16]};
							dq_q    <= {mag_a[15:0], 16'd0};
							dvs_q   <= mag_b;
							ovf_q   <= div_ovf;
							cnt_q   <= '0;
							state_q <= S_DIV;
						end
						default: begin
							top_q   <= addsub_res;
							depth_q <= depth_q - DEPTH_W'(1);
							state_q <= S_DONE;
						end
					endcase
				end
				S_MULSAT: begin
					top_q   <= sat_mag(prod_q[63:16], neg_q);
					depth_q <= depth_q - DEPTH_W'(1);
					state_q <= S_DONE;
				end
				S_DIV: begin
					// restoring step: keep the difference when the trial is not below the divisor
					rem_q <= alu_neg ? div_trial[31:0] : alu_sum[31:0];
					dq_q  <= {dq_q[30:0], !alu_neg};
					cnt_q <= cnt_q + DIV_CNT_W'(1);
					if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_q <= S_DIVEND;
				end
				S_DIVEND: begin
					top_q   <= sat_mag(ovf_q ? 48'hFFFF_FFFF_FFFF : {16'd0, dq_q}, neg_q);
					depth_q <= depth_q - DEPTH_W'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_load) begin
						res_q.status        <= st_q;
						res_q.printed_value <= printed_q;
						res_q.print_valid   <= pvalid_q;
						res_q.stack_depth   <= 5'(depth_q);
						res_q.top_value     <= empty ? '0 : top_q;
						state_q             <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(STACK_DEPTH))
		else $error("stack depth beyond capacity");

	a_empty_top_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.stack_depth == 5'd0 |-> res.top_value == '0)
		else $error("empty stack reports nonzero top");

	a_print_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.print_valid |-> res.status == ST_OK)
		else $error("print flagged on a failed instruction");

	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && cnt_q == DIV_CNT_W'(DIV_STEPS - 1) |=> state_q == S_DIVEND)
		else $error("divider did not finish after its last step");

	a_fail_keeps_depth: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC && !exec_ok |=> depth_q == $past(depth_q) && top_q == $past(top_q))
		else $error("failed instruction changed the stack");

endmodule
`default_nettype wire
